// ===== rtl/sbrtc_pkg.sv =====
package sbrtc_pkg;

    localparam int BYTE_COUNT = 7;
    localparam int IDX_W      = 3;

    localparam logic [IDX_W-1:0] IDX_HOUR = 3'd0;
    localparam logic [IDX_W-1:0] IDX_MIN  = 3'd1;
    localparam logic [IDX_W-1:0] IDX_DAY  = 3'd2;
    localparam logic [IDX_W-1:0] IDX_MON  = 3'd3;
    localparam logic [IDX_W-1:0] IDX_YEAR = 3'd4;
    localparam logic [IDX_W-1:0] IDX_WDAY = 3'd5;
    localparam logic [IDX_W-1:0] IDX_SEC  = 3'd6;

    localparam logic [7:0] FPS_RESET = 8'd50;
    localparam logic [3:0] CMD_READ  = 4'hF;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_CMD   = 2'd1,
        PH_READ  = 2'd2,
        PH_WRITE = 2'd3
    } t_phase;

    typedef struct packed {
        logic             tick;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic [7:0]       wr_data;
    } t_tk_ctrl;

    // high digit * 10 + low digit + 1, digits 0..15
    function automatic logic [7:0] bcd_value_inc(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'd0, b[7:4]};
        return (hi << 3) + (hi << 1) + {4'd0, b[3:0]} + 8'd1;
    endfunction

    // binary 0..99 to two BCD digits, divide by ten via reciprocal
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [15:0] prod;
        logic [3:0]  q;
        logic [6:0]  r;
        prod = {9'd0, v} * 16'd205;
        q    = prod[14:11];
        r    = v - (7'({3'd0, q}) << 3) - (7'({3'd0, q}) << 1);
        return {q, r[3:0]};
    endfunction

    // returns {carry, next byte}
    function automatic logic [8:0] bcd_step(input logic [7:0] b,
                                            input logic [7:0] ceiling,
                                            input logic [7:0] floor_bcd);
        logic [7:0] v;
        v = bcd_value_inc(b);
        if (v > ceiling) begin
            return {1'b1, floor_bcd};
        end
        return {1'b0, to_bcd(v[6:0])};
    endfunction

endpackage

// ===== rtl/sbrtc_timekeeper.sv =====
module sbrtc_timekeeper
    import sbrtc_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_tk_ctrl                    i_ctrl,
    input  logic                        i_cfg_we,
    input  logic [7:0]                  i_cfg_data,
    output logic [BYTE_COUNT-1:0][7:0]  o_time_bytes
);

    logic [BYTE_COUNT-1:0][7:0] r_time;
    logic [BYTE_COUNT-1:0][7:0] n_time;
    logic [7:0]                 r_fps;
    logic [7:0]                 r_countdown;
    logic [7:0]                 n_countdown;

    logic [7:0] cnt_dec;
    logic       adv;
    logic [8:0] st_sec, st_min, st_hour, st_day, st_mon;
    logic [7:0] yr_v;
    logic [7:0] yr_m;
    logic [3:0] wd_lo;
    logic [3:0] wd_m;

    assign cnt_dec = r_countdown - 8'd1;
    assign adv     = i_ctrl.tick && (cnt_dec == 8'd0);

    assign st_sec  = bcd_step(r_time[IDX_SEC],  8'd59, 8'h00);
    assign st_min  = bcd_step(r_time[IDX_MIN],  8'd59, 8'h00);
    assign st_hour = bcd_step(r_time[IDX_HOUR], 8'd23, 8'h00);
    assign st_day  = bcd_step(r_time[IDX_DAY],  8'd31, 8'h01);
    assign st_mon  = bcd_step(r_time[IDX_MON],  8'd12, 8'h01);

    assign yr_v = bcd_value_inc(r_time[IDX_YEAR]);
    assign yr_m = (yr_v >= 8'd100) ? yr_v - 8'd100 : yr_v;

    assign wd_lo = r_time[IDX_WDAY][3:0];
    assign wd_m  = (wd_lo >= 4'd14) ? wd_lo - 4'd14 :
                   (wd_lo >= 4'd7)  ? wd_lo - 4'd7  : wd_lo;

    always_comb begin
        n_time      = r_time;
        n_countdown = r_countdown;
        if (i_ctrl.tick) begin
            n_countdown = adv ? r_fps : cnt_dec;
        end
        if (adv) begin
            n_time[IDX_SEC] = st_sec[7:0];
            if (st_sec[8]) begin
                n_time[IDX_MIN] = st_min[7:0];
                if (st_min[8]) begin
                    n_time[IDX_HOUR] = st_hour[7:0];
                    if (st_hour[8]) begin
                        n_time[IDX_WDAY] = {4'd0, wd_m + 4'd1};
                        n_time[IDX_DAY]  = st_day[7:0];
                        if (st_day[8]) begin
                            n_time[IDX_MON] = st_mon[7:0];
                            if (st_mon[8]) begin
                                n_time[IDX_YEAR] = to_bcd(yr_m[6:0]);
                            end
                        end
                    end
                end
            end
        end
        if (i_ctrl.wr_en && (i_ctrl.wr_idx < IDX_W'(BYTE_COUNT))) begin
            n_time[i_ctrl.wr_idx] = i_ctrl.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time[IDX_HOUR] <= 8'h00;
            r_time[IDX_MIN]  <= 8'h00;
            r_time[IDX_DAY]  <= 8'h01;
            r_time[IDX_MON]  <= 8'h01;
            r_time[IDX_YEAR] <= 8'h00;
            r_time[IDX_WDAY] <= 8'h01;
            r_time[IDX_SEC]  <= 8'h00;
            r_fps            <= FPS_RESET;
            r_countdown      <= FPS_RESET;
        end else begin
            r_time      <= n_time;
            r_countdown <= n_countdown;
            if (i_cfg_we) begin
                r_fps <= i_cfg_data;
            end
        end
    end

    assign o_time_bytes = r_time;

endmodule

// ===== rtl/serial_bcd_real_time_clock.sv =====
// Serial BCD real-time clock. Seven BCD time bytes (hour, minute, day, month,
// year, weekday, second) advance once every frames_per_second frame ticks and
// are read or written over a three-wire serial port that the host bit-bangs
// one port byte at a time. Each input word (tuser 0 = frame tick, 1 = port
// write) produces one output word with the serial output bit and the transfer
// phase after the update. The whole update is a single pass from the state
// registers to the output register, so one word is accepted per clock while
// the output register can drain.
module serial_bcd_real_time_clock
    import sbrtc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] port_data
    input  logic       s_axis_tuser,   // [0] action
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [0] miso, [2:1] transfer_phase, [7:3] zero
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data      // frames_per_second
);

    t_phase           r_phase, n_phase;
    logic             r_ck_prev, n_ck_prev;
    logic [2:0]       r_cmd_cnt, n_cmd_cnt;
    logic [3:0]       r_cmd_val, n_cmd_val;
    logic [IDX_W-1:0] r_byte_idx, n_byte_idx;
    logic [2:0]       r_bit_idx, n_bit_idx;
    logic [7:0]       r_shift, n_shift;
    logic             r_serial, n_serial;

    logic       r_out_valid;
    logic       r_out_miso;
    t_phase     r_out_phase;

    t_tk_ctrl                   tk_ctrl;
    logic [BYTE_COUNT-1:0][7:0] time_bytes;

    logic       accept;
    logic       port;
    logic       ck, cs, io;
    logic       zero;
    logic       rising, falling;
    logic       cmd_take;
    logic [3:0] cmd_base_val;
    logic [2:0] cmd_base_cnt;
    logic [3:0] cmd_new_val;
    logic [2:0] cmd_new_cnt;
    logic       cmd_done;
    t_phase     cmd_kind;
    logic       last_byte;
    logic [7:0] wr_byte;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign port          = accept && s_axis_tuser;
    assign o_cfg_ready   = 1'b1;

    assign ck      = s_axis_tdata[3];
    assign cs      = s_axis_tdata[2];
    assign io      = s_axis_tdata[0];
    assign zero    = (s_axis_tdata == 8'd0);
    assign rising  = !r_ck_prev && ck;
    assign falling = r_ck_prev && !ck;

    assign cmd_take = port && !zero && rising &&
                      (((r_phase == PH_IDLE) && cs) || (r_phase == PH_CMD));
    assign cmd_base_val = (r_phase == PH_IDLE) ? 4'd0 : r_cmd_val;
    assign cmd_base_cnt = (r_phase == PH_IDLE) ? 3'd0 : r_cmd_cnt;
    assign cmd_new_val  = cmd_base_val | (4'(io) << cmd_base_cnt[1:0]);
    assign cmd_new_cnt  = cmd_base_cnt + 3'd1;
    assign cmd_done     = cmd_new_cnt[2];
    assign cmd_kind     = (cmd_new_val == CMD_READ) ? PH_READ : PH_WRITE;

    assign last_byte = (r_byte_idx >= IDX_W'(BYTE_COUNT - 1));
    assign wr_byte   = r_shift | (8'(io) << r_bit_idx);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (port) begin
            if (zero) begin
                n_phase = PH_IDLE;
            end else begin
                case (r_phase)
                    PH_IDLE: begin
                        if (cs && !ck) begin
                            n_phase = PH_CMD;
                        end else if (cmd_take) begin
                            n_phase = cmd_done ? cmd_kind : PH_CMD;
                        end
                    end
                    PH_CMD: begin
                        if (cmd_take && cmd_done) begin
                            n_phase = cmd_kind;
                        end
                    end
                    PH_READ: begin
                        if (falling && (r_bit_idx == 3'd7) && last_byte) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_WRITE: begin
                        if (rising && (r_bit_idx == 3'd7) && last_byte) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // datapath
    always_comb begin
        n_ck_prev       = r_ck_prev;
        n_cmd_cnt       = r_cmd_cnt;
        n_cmd_val       = r_cmd_val;
        n_byte_idx      = r_byte_idx;
        n_bit_idx       = r_bit_idx;
        n_shift         = r_shift;
        n_serial        = r_serial;
        tk_ctrl.tick    = accept && !s_axis_tuser;
        tk_ctrl.wr_en   = 1'b0;
        tk_ctrl.wr_idx  = r_byte_idx;
        tk_ctrl.wr_data = wr_byte;
        if (port) begin
            if (zero) begin
                n_serial  = 1'b0;
                n_ck_prev = 1'b0;
            end else begin
                n_ck_prev = ck;
                if (r_phase == PH_IDLE && cs && !ck) begin
                    n_cmd_cnt = 3'd0;
                    n_cmd_val = 4'd0;
                end
                if (cmd_take) begin
                    n_cmd_cnt = cmd_new_cnt;
                    n_cmd_val = cmd_new_val;
                    if (cmd_done) begin
                        n_byte_idx = '0;
                        n_bit_idx  = 3'd0;
                        if (cmd_kind == PH_WRITE) begin
                            n_shift = 8'd0;
                        end
                    end
                end
                if (r_phase == PH_READ && falling) begin
                    n_serial  = (r_byte_idx < IDX_W'(BYTE_COUNT)) ?
                                time_bytes[r_byte_idx][r_bit_idx] : 1'b0;
                    n_bit_idx = r_bit_idx + 3'd1;
                    if (r_bit_idx == 3'd7) begin
                        n_byte_idx = r_byte_idx + IDX_W'(1);
                    end
                end
                if (r_phase == PH_WRITE && rising) begin
                    n_bit_idx = r_bit_idx + 3'd1;
                    if (r_bit_idx == 3'd7) begin
                        tk_ctrl.wr_en = 1'b1;
                        n_byte_idx    = r_byte_idx + IDX_W'(1);
                        n_shift       = 8'd0;
                    end else begin
                        n_shift = wr_byte;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_ck_prev   <= 1'b0;
            r_cmd_cnt   <= 3'd0;
            r_cmd_val   <= 4'd0;
            r_byte_idx  <= '0;
            r_bit_idx   <= 3'd0;
            r_shift     <= 8'd0;
            r_serial    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_ck_prev  <= n_ck_prev;
            r_cmd_cnt  <= n_cmd_cnt;
            r_cmd_val  <= n_cmd_val;
            r_byte_idx <= n_byte_idx;
            r_bit_idx  <= n_bit_idx;
            r_shift    <= n_shift;
            r_serial   <= n_serial;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_miso  <= n_serial;
            r_out_phase <= n_phase;
        end
    end

    sbrtc_timekeeper u_timekeeper (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (tk_ctrl),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_time_bytes (time_bytes)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_phase, r_out_miso};

endmodule
